@@ src/pfg_pkg.sv @@
// Package for the particle force generator: mode and register index codes,
// sideband structures carried along the pipeline and the saturation helper.
// Depends on nothing; the top level, pfg_mul and the testbench import it.
package pfg_pkg;

    localparam logic [1:0] MODE_GRAVITY  = 2'd0;
    localparam logic [1:0] MODE_SPRING   = 2'd1;
    localparam logic [1:0] MODE_ANCHORED = 2'd2;
    localparam logic [1:0] MODE_BUNGEE   = 2'd3;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPRING_K  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REST_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_X = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_Y = 3'd6;

    localparam int DIFF_W = 33;
    localparam int LEN_W  = 33;
    localparam int DISP_W = 34;
    localparam int REST_W = 31;

    typedef struct packed {
        logic              grav_mode;
        logic              grav_on;
        logic              bungee;
        logic signed [31:0] fgx;
        logic signed [31:0] fgy;
    } ctl_t;

    typedef struct packed {
        ctl_t              ctl;
        logic              dx_neg;
        logic              dy_neg;
        logic              halved;
        logic [DIFF_W-1:0] a;
        logic [DIFF_W-1:0] b;
    } sq_side_t;

    typedef struct packed {
        ctl_t                     ctl;
        logic                     dx_neg;
        logic                     dy_neg;
        logic                     spring_on;
        logic signed [DISP_W-1:0] disp;
    } dv_side_t;

    typedef struct packed {
        ctl_t ctl;
        logic spring_on;
    } ml_side_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        else if (v < -64'sd2147483648)
        begin
            return 32'sh80000000;
        end
        else
        begin
            return $signed(v[31:0]);
        end
    endfunction

endpackage

@@ src/particle_force_generator_top.sv @@
// Top level of the particle force generator: configuration registers, front
// end, length, unit vector and force stages. Uses pfg_pkg and the submodules.
//
//  channel  direction  handshake               payload
//  cfg      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//  in       in         in_valid / in_stall     pos_x, pos_y, other_x, other_y, mass, finite_mass
//  out      out        out_valid / out_stall   force_x, force_y, force_applied
//
// One beat enters per cycle while in_stall is low; the path runs through the
// 32-stage square root and the FRAC_BITS + 2 stage divider.
// Reset clears the configuration registers and all valid bits; configuration reads as zero.
// A stalled output beat freezes the whole pipeline, so nothing is lost or doubled.
module particle_force_generator_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] other_x,
    input  logic [31:0] other_y,
    input  logic [31:0] mass,
    input  logic        finite_mass,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] force_x,
    output logic [31:0] force_y,
    output logic        force_applied
);

    import pfg_pkg::*;

    localparam int QW = FRAC_BITS + 2;
    localparam int UW = QW + 1;
    localparam int NW = DIFF_W + FRAC_BITS;
    localparam logic [LEN_W-1:0] EPS = LEN_W'((1 << FRAC_BITS) / 10000);
    localparam logic signed [64:0] PROD_LIM = 65'sd1 <<< 62;

    function automatic logic signed [31:0] grav_force(input logic signed [64:0] p);
        logic signed [64:0] c;
        logic signed [64:0] sh;
        c = p;
        if (p > PROD_LIM)
        begin
            c = PROD_LIM;
        end
        else if (p < -PROD_LIM)
        begin
            c = -PROD_LIM;
        end
        sh = c >>> FRAC_BITS;
        return sat32(sh[63:0]);
    endfunction

    logic [1:0]  mode_reg;
    logic [31:0] spring_k_reg;
    logic [REST_W-1:0] rest_reg;
    logic [31:0] anchor_x_reg;
    logic [31:0] anchor_y_reg;
    logic [31:0] gravity_x_reg;
    logic [31:0] gravity_y_reg;

    logic adv;

    assign cfg_ready = 1'b1;
    assign adv       = !(out_valid && out_stall);
    assign in_stall  = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_GRAVITY;
            spring_k_reg  <= '0;
            rest_reg      <= '0;
            anchor_x_reg  <= '0;
            anchor_y_reg  <= '0;
            gravity_x_reg <= '0;
            gravity_y_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MODE:      mode_reg      <= cfg_data[1:0];
                REG_SPRING_K:  spring_k_reg  <= cfg_data;
                REG_REST_LEN:  rest_reg      <= cfg_data[REST_W-1:0];
                REG_ANCHOR_X:  anchor_x_reg  <= cfg_data;
                REG_ANCHOR_Y:  anchor_y_reg  <= cfg_data;
                REG_GRAVITY_X: gravity_x_reg <= cfg_data;
                REG_GRAVITY_Y: gravity_y_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Front end, stage 1: differences, magnitudes and gravity products.
    logic [31:0]              ox;
    logic [31:0]              oy;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [DIFF_W-1:0]        a_next;
    logic [DIFF_W-1:0]        b_next;
    logic signed [64:0]       gpx_next;
    logic signed [64:0]       gpy_next;

    assign ox       = (mode_reg == MODE_ANCHORED) ? anchor_x_reg : other_x;
    assign oy       = (mode_reg == MODE_ANCHORED) ? anchor_y_reg : other_y;
    assign dx       = $signed({pos_x[31], pos_x}) - $signed({ox[31], ox});
    assign dy       = $signed({pos_y[31], pos_y}) - $signed({oy[31], oy});
    assign a_next   = dx[DIFF_W-1] ? (DIFF_W'(0) - dx) : dx;
    assign b_next   = dy[DIFF_W-1] ? (DIFF_W'(0) - dy) : dy;
    assign gpx_next = $signed(gravity_x_reg) * $signed({1'b0, mass});
    assign gpy_next = $signed(gravity_y_reg) * $signed({1'b0, mass});

    logic               s1_v_reg;
    logic [DIFF_W-1:0]  s1_a_reg;
    logic [DIFF_W-1:0]  s1_b_reg;
    logic               s1_dxneg_reg;
    logic               s1_dyneg_reg;
    logic signed [64:0] s1_gpx_reg;
    logic signed [64:0] s1_gpy_reg;
    logic               s1_grav_reg;
    logic               s1_on_reg;
    logic               s1_bungee_reg;

    // Stage 2: squares of the (possibly halved) magnitudes, gravity force.
    logic               halved;
    logic [30:0]        oa;
    logic [30:0]        ob;
    logic [61:0]        sqa_next;
    logic [61:0]        sqb_next;

    assign halved   = s1_a_reg[32] | s1_a_reg[31] | s1_b_reg[32] | s1_b_reg[31];
    assign oa       = halved ? s1_a_reg[31:1] : s1_a_reg[30:0];
    assign ob       = halved ? s1_b_reg[31:1] : s1_b_reg[30:0];
    assign sqa_next = oa * oa;
    assign sqb_next = ob * ob;

    logic        s2_v_reg;
    logic [61:0] s2_sqa_reg;
    logic [61:0] s2_sqb_reg;
    sq_side_t    s2_side_reg;
    sq_side_t    s2_side_next;

    always_comb
    begin
        s2_side_next.ctl.grav_mode = s1_grav_reg;
        s2_side_next.ctl.grav_on   = s1_on_reg;
        s2_side_next.ctl.bungee    = s1_bungee_reg;
        s2_side_next.ctl.fgx       = grav_force(s1_gpx_reg);
        s2_side_next.ctl.fgy       = grav_force(s1_gpy_reg);
        s2_side_next.dx_neg        = s1_dxneg_reg;
        s2_side_next.dy_neg        = s1_dyneg_reg;
        s2_side_next.halved        = halved;
        s2_side_next.a             = s1_a_reg;
        s2_side_next.b             = s1_b_reg;
    end

    // Stage 3: sum of squares.
    logic        s3_v_reg;
    logic [62:0] s3_rad_reg;
    sq_side_t    s3_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_a_reg      <= a_next;
            s1_b_reg      <= b_next;
            s1_dxneg_reg  <= dx[DIFF_W-1];
            s1_dyneg_reg  <= dy[DIFF_W-1];
            s1_gpx_reg    <= gpx_next;
            s1_gpy_reg    <= gpy_next;
            s1_grav_reg   <= (mode_reg == MODE_GRAVITY);
            s1_on_reg     <= finite_mass;
            s1_bungee_reg <= (mode_reg == MODE_BUNGEE);
            s2_sqa_reg    <= sqa_next;
            s2_sqb_reg    <= sqb_next;
            s2_side_reg   <= s2_side_next;
            s3_rad_reg    <= {1'b0, s2_sqa_reg} + {1'b0, s2_sqb_reg};
            s3_side_reg   <= s2_side_reg;
        end
    end

    logic        sq_v;
    logic [31:0] sq_root;
    sq_side_t    sq_side;

    pfg_sqrt #(
        .RW  (32),
        .SBW ($bits(sq_side_t))
    ) u_sqrt (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (adv),
        .vin    (s3_v_reg),
        .s      ({1'b0, s3_rad_reg}),
        .sb_in  (s3_side_reg),
        .vout   (sq_v),
        .root   (sq_root),
        .sb_out (sq_side)
    );

    // Length stage: scale back, test the no-force cases, displacement.
    logic [LEN_W-1:0]  len;
    dv_side_t          l_side_next;
    logic              l_v_reg;
    logic [LEN_W-1:0]  l_len_reg;
    logic [DIFF_W-1:0] l_a_reg;
    logic [DIFF_W-1:0] l_b_reg;
    dv_side_t          l_side_reg;

    assign len = sq_side.halved ? {sq_root, 1'b0} : {1'b0, sq_root};

    always_comb
    begin
        l_side_next.ctl       = sq_side.ctl;
        l_side_next.dx_neg    = sq_side.dx_neg;
        l_side_next.dy_neg    = sq_side.dy_neg;
        l_side_next.spring_on = (len > EPS) &&
                                !(sq_side.ctl.bungee && (len <= LEN_W'(rest_reg)));
        l_side_next.disp      = $signed({1'b0, len}) - $signed({3'b000, rest_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            l_v_reg <= sq_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l_len_reg  <= len;
            l_a_reg    <= sq_side.a;
            l_b_reg    <= sq_side.b;
            l_side_reg <= l_side_next;
        end
    end

    logic              dv_v;
    logic [1:0][QW-1:0] dv_quo;
    dv_side_t          dv_side;

    pfg_div #(
        .DW  (LEN_W),
        .NW  (NW),
        .QW  (QW),
        .SBW ($bits(dv_side_t))
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (adv),
        .vin    (l_v_reg),
        .num    ({{l_b_reg, FRAC_BITS'(0)}, {l_a_reg, FRAC_BITS'(0)}}),
        .den    (l_len_reg),
        .sb_in  (l_side_reg),
        .vout   (dv_v),
        .quo    (dv_quo),
        .sb_out (dv_side)
    );

    logic [1:0][UW-1:0] unit;
    ml_side_t           ml_side_in;
    logic               ml_v;
    logic [1:0][31:0]   ml_force;
    ml_side_t           ml_side;

    always_comb
    begin
        unit[0] = dv_side.dx_neg ? (UW'(0) - {1'b0, dv_quo[0]}) : {1'b0, dv_quo[0]};
        unit[1] = dv_side.dy_neg ? (UW'(0) - {1'b0, dv_quo[1]}) : {1'b0, dv_quo[1]};
        ml_side_in.ctl       = dv_side.ctl;
        ml_side_in.spring_on = dv_side.spring_on;
    end

    pfg_mul #(
        .FRAC (FRAC_BITS),
        .UW   (UW),
        .SBW  ($bits(ml_side_t))
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .vin     (dv_v),
        .k       (spring_k_reg),
        .u       (unit),
        .disp    (dv_side.disp),
        .sb_in   (ml_side_in),
        .vout    (ml_v),
        .force_q (ml_force),
        .sb_out  (ml_side)
    );

    // Output register: choose gravity or spring result, or zero when no force applies.
    logic        out_valid_reg;
    logic [31:0] force_x_reg;
    logic [31:0] force_y_reg;
    logic        applied_reg;
    logic        applied_next;
    logic [31:0] fx_next;
    logic [31:0] fy_next;

    always_comb
    begin
        if (ml_side.ctl.grav_mode)
        begin
            applied_next = ml_side.ctl.grav_on;
            fx_next      = ml_side.ctl.fgx;
            fy_next      = ml_side.ctl.fgy;
        end
        else
        begin
            applied_next = ml_side.spring_on;
            fx_next      = ml_force[0];
            fy_next      = ml_force[1];
        end
        if (!applied_next)
        begin
            fx_next = '0;
            fy_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= ml_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            force_x_reg <= fx_next;
            force_y_reg <= fy_next;
            applied_reg <= applied_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign force_x       = force_x_reg;
    assign force_y       = force_y_reg;
    assign force_applied = applied_reg;

    a_zero_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !force_applied |-> force_x == '0 && force_y == '0)
        else $error("force present on a beat with no force applied");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while the output beat is stalled");

    a_frozen_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> out_valid)
        else $error("output beat lost during a stall");

    a_slack_bungee: assert property (@(posedge clk) disable iff (!rst_n)
        l_v_reg && l_side_reg.ctl.bungee && (l_len_reg <= LEN_W'(rest_reg))
        |-> !l_side_reg.spring_on)
        else $error("slack bungee marked as pulling");

endmodule

@@ src/pfg_sqrt.sv @@
// Pipelined integer square root, one result bit per register stage.
// Stand-alone; a sideband vector travels with each beat.
module pfg_sqrt #(
    parameter int RW  = 32,
    parameter int SBW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            vin,
    input  logic [2*RW-1:0] s,
    input  logic [SBW-1:0]  sb_in,
    output logic            vout,
    output logic [RW-1:0]   root,
    output logic [SBW-1:0]  sb_out
);

    logic [RW+1:0]   rem_s  [0:RW];
    logic [RW-1:0]   root_s [0:RW];
    logic [2*RW-1:0] rad_s  [0:RW];
    logic [SBW-1:0]  sb_s   [0:RW];
    logic            v_s    [0:RW];

    assign rem_s[0]  = '0;
    assign root_s[0] = '0;
    assign rad_s[0]  = s;
    assign sb_s[0]   = sb_in;
    assign v_s[0]    = vin;

    for (genvar i = 0; i < RW; i++)
    begin : g_stage
        logic [RW+1:0]   cur;
        logic [RW+1:0]   trial;
        logic            ge;
        logic [RW+1:0]   rem_next;
        logic [RW-1:0]   root_next;
        logic [RW+1:0]   rem_reg;
        logic [RW-1:0]   root_reg;
        logic [2*RW-1:0] rad_reg;
        logic [SBW-1:0]  sb_reg;
        logic            v_reg;

        assign cur       = {rem_s[i][RW-1:0], rad_s[i][2*RW-1 -: 2]};
        assign trial     = {root_s[i], 2'b01};
        assign ge        = (cur >= trial);
        assign rem_next  = ge ? (cur - trial) : cur;
        assign root_next = {root_s[i][RW-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= v_s[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= rem_next;
                root_reg <= root_next;
                rad_reg  <= rad_s[i] << 2;
                sb_reg   <= sb_s[i];
            end
        end

        assign rem_s[i+1]  = rem_reg;
        assign root_s[i+1] = root_reg;
        assign rad_s[i+1]  = rad_reg;
        assign sb_s[i+1]   = sb_reg;
        assign v_s[i+1]    = v_reg;
    end

    assign vout   = v_s[RW];
    assign root   = root_s[RW];
    assign sb_out = sb_s[RW];

endmodule

@@ src/pfg_div.sv @@
// Pipelined two-lane restoring divider sharing one divisor, one quotient
// bit per register stage. Stand-alone; a sideband vector travels along.
module pfg_div #(
    parameter int DW  = 33,
    parameter int NW  = 49,
    parameter int QW  = 18,
    parameter int SBW = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                vin,
    input  logic [1:0][NW-1:0]  num,
    input  logic [DW-1:0]       den,
    input  logic [SBW-1:0]      sb_in,
    output logic                vout,
    output logic [1:0][QW-1:0]  quo,
    output logic [SBW-1:0]      sb_out
);

    logic [1:0][DW-1:0] r_s  [0:QW];
    logic [1:0][QW-1:0] q_s  [0:QW];
    logic [1:0][QW-1:0] n_s  [0:QW];
    logic [DW-1:0]      d_s  [0:QW];
    logic [SBW-1:0]     sb_s [0:QW];
    logic               v_s  [0:QW];

    assign r_s[0]  = {DW'(num[1][NW-1:QW]), DW'(num[0][NW-1:QW])};
    assign n_s[0]  = {num[1][QW-1:0], num[0][QW-1:0]};
    assign q_s[0]  = '0;
    assign d_s[0]  = den;
    assign sb_s[0] = sb_in;
    assign v_s[0]  = vin;

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic [1:0][DW:0]   trial;
        logic [1:0][DW:0]   diff;
        logic [1:0]         ge;
        logic [1:0][DW-1:0] r_next;
        logic [1:0][QW-1:0] q_next;
        logic [1:0][QW-1:0] n_next;
        logic [1:0][DW-1:0] r_reg;
        logic [1:0][QW-1:0] q_reg;
        logic [1:0][QW-1:0] n_reg;
        logic [DW-1:0]      d_reg;
        logic [SBW-1:0]     sb_reg;
        logic               v_reg;

        always_comb
        begin
            for (int l = 0; l < 2; l++)
            begin
                trial[l]  = {r_s[i][l], n_s[i][l][QW-1]};
                diff[l]   = trial[l] - {1'b0, d_s[i]};
                ge[l]     = (trial[l] >= {1'b0, d_s[i]});
                r_next[l] = ge[l] ? diff[l][DW-1:0] : trial[l][DW-1:0];
                q_next[l] = {q_s[i][l][QW-2:0], ge[l]};
                n_next[l] = {n_s[i][l][QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= v_s[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg  <= r_next;
                q_reg  <= q_next;
                n_reg  <= n_next;
                d_reg  <= d_s[i];
                sb_reg <= sb_s[i];
            end
        end

        assign r_s[i+1]  = r_reg;
        assign q_s[i+1]  = q_reg;
        assign n_s[i+1]  = n_reg;
        assign d_s[i+1]  = d_reg;
        assign sb_s[i+1] = sb_reg;
        assign v_s[i+1]  = v_reg;
    end

    assign vout   = v_s[QW];
    assign quo    = q_s[QW];
    assign sb_out = sb_s[QW];

endmodule

@@ src/pfg_mul.sv @@
// Five-stage two-lane spring force multiplier: k*u, then times displacement
// with product clamping, negation and saturation. Depends on pfg_pkg.
module pfg_mul #(
    parameter int FRAC = 16,
    parameter int UW   = 19,
    parameter int SBW  = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               vin,
    input  logic [31:0]        k,
    input  logic [1:0][UW-1:0] u,
    input  logic [33:0]        disp,
    input  logic [SBW-1:0]     sb_in,
    output logic               vout,
    output logic [1:0][31:0]   force_q,
    output logic [SBW-1:0]     sb_out
);

    import pfg_pkg::*;

    localparam int PW = 32 + UW;
    localparam logic [63:0] ROUND = (64'd1 << FRAC) - 64'd1;
    localparam logic [65:0] LIM   = 66'd1 << 62;

    logic [4:0]         v_reg;
    logic [SBW-1:0]     sb_reg [0:4];

    logic [1:0][PW-1:0] pk_reg;
    logic [33:0]        disp1_reg;
    logic [1:0][32:0]   kmag_reg;
    logic [1:0]         neg2_reg;
    logic [32:0]        dmag_reg;
    logic [1:0][49:0]   pl_reg;
    logic [1:0][48:0]   ph_reg;
    logic [1:0]         neg3_reg;
    logic [1:0][62:0]   pc_reg;
    logic [1:0]         neg4_reg;
    logic [1:0][31:0]   force_reg;

    logic signed [PW-1:0] pk_next [0:1];
    logic signed [PW-1:0] shv     [0:1];
    logic [33:0]          kd      [0:1];
    logic [33:0]          kabs    [0:1];
    logic [33:0]          dabs;
    logic [1:0][49:0]     pl_next;
    logic [1:0][48:0]     ph_next;
    logic [65:0]          sum     [0:1];
    logic [1:0][62:0]     pc_next;
    logic [63:0]          up      [0:1];
    logic [63:0]          dn      [0:1];
    logic signed [63:0]   rv      [0:1];
    logic [1:0][31:0]     force_next;

    always_comb
    begin
        dabs = disp1_reg[33] ? (34'd0 - disp1_reg) : disp1_reg;
        for (int l = 0; l < 2; l++)
        begin
            pk_next[l]    = $signed(k) * $signed(u[l]);
            shv[l]        = $signed(pk_reg[l]) >>> FRAC;
            kd[l]         = shv[l][33:0];
            kabs[l]       = kd[l][33] ? (34'd0 - kd[l]) : kd[l];
            pl_next[l]    = kmag_reg[l] * dmag_reg[16:0];
            ph_next[l]    = kmag_reg[l] * dmag_reg[32:17];
            sum[l]        = {16'd0, pl_reg[l]} + {ph_reg[l], 17'd0};
            pc_next[l]    = (sum[l] > LIM) ? LIM[62:0] : sum[l][62:0];
            up[l]         = (64'(pc_reg[l]) + ROUND) >> FRAC;
            dn[l]         = 64'(pc_reg[l]) >> FRAC;
            rv[l]         = neg4_reg[l] ? $signed(up[l]) : -$signed(dn[l]);
            force_next[l] = sat32(rv[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[3:0], vin};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0] <= sb_in;
            for (int j = 1; j < 5; j++)
            begin
                sb_reg[j] <= sb_reg[j-1];
            end
            disp1_reg <= disp;
            dmag_reg  <= dabs[32:0];
            for (int l = 0; l < 2; l++)
            begin
                pk_reg[l]    <= pk_next[l];
                kmag_reg[l]  <= kabs[l][32:0];
                neg2_reg[l]  <= kd[l][33] ^ disp1_reg[33];
                pl_reg[l]    <= pl_next[l];
                ph_reg[l]    <= ph_next[l];
                neg3_reg[l]  <= neg2_reg[l];
                pc_reg[l]    <= pc_next[l];
                neg4_reg[l]  <= neg3_reg[l];
                force_reg[l] <= force_next[l];
            end
        end
    end

    assign vout    = v_reg[4];
    assign sb_out  = sb_reg[4];
    assign force_q = force_reg;

endmodule

@@ dv/particle_force_generator_top_tb.sv @@
// Self-checking testbench for particle_force_generator_top: directed table then random beats,
// each result compared with a table entry or a behavioural force predictor held in this file.
// Depends on pfg_pkg and the block's RTL only.
`timescale 1ns / 100ps

module particle_force_generator_top_tb;
    import pfg_pkg::*;

    localparam int FRAC = 16;
    localparam int LATENCY = FRAC + 44;
    localparam longint EPS_RAW = (64'sd1 <<< FRAC) / 10000;
    localparam longint PROD_LIM = 64'sd1 <<< 62;

    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] ox;
        logic [31:0] oy;
        logic [31:0] m;
        logic        fin;
    } particle_t;

    typedef struct packed {
        logic [31:0] fx;
        logic [31:0] fy;
        logic        applied;
    } force_t;

    typedef struct {
        particle_t p;
        logic      known;
        force_t    f;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] pos_x = '0, pos_y = '0, other_x = '0, other_y = '0, mass = '0;
    logic        finite_mass = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] force_x, force_y;
    logic        force_applied;

    logic [1:0]  cur_mode = MODE_GRAVITY;
    logic [31:0] cur_k = '0, cur_ax = '0, cur_ay = '0, cur_gx = '0, cur_gy = '0;
    logic [30:0] cur_rest = '0;

    force_t pending_forces[$];
    int     n_errors = 0;
    bit     quiet_tail = 0;
    bit     hold_long = 0;

    particle_force_generator_top #(.FRAC_BITS(FRAC)) uut (.*);

    always #10 clk = ~clk;

    function automatic longint floor_q(longint x);
        return x >>> FRAC;
    endfunction

    function automatic longint mul_q(longint a, longint b);
        longint ua, ub;
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        if (ua != 0 && ub > PROD_LIM / ua)
            return floor_q(((a < 0) != (b < 0)) ? -PROD_LIM : PROD_LIM);
        return floor_q(a * b);
    endfunction

    function automatic longint clip32(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint root_floor(longint unsigned s);
        longint unsigned r, t;
        r = 0;
        for (int bit_i = 31; bit_i >= 0; bit_i--)
        begin
            t = r | (64'd1 << bit_i);
            if (t * t <= s)
                r = t;
        end
        return longint'(r);
    endfunction

    function automatic force_t spring_force(particle_t p);
        force_t r;
        longint px, py, ox, oy, dx, dy, len, rest, disp, k, ux, uy;
        longint unsigned a, b;
        r = '0;
        if (cur_mode == MODE_GRAVITY)
        begin
            if (p.fin)
            begin
                r.fx = 32'(clip32(mul_q(longint'($signed(cur_gx)), longint'(p.m))));
                r.fy = 32'(clip32(mul_q(longint'($signed(cur_gy)), longint'(p.m))));
                r.applied = 1'b1;
            end
            return r;
        end
        px = $signed(p.px);
        py = $signed(p.py);
        ox = cur_mode == MODE_ANCHORED ? longint'($signed(cur_ax)) : longint'($signed(p.ox));
        oy = cur_mode == MODE_ANCHORED ? longint'($signed(cur_ay)) : longint'($signed(p.oy));
        dx = px - ox;
        dy = py - oy;
        a = dx < 0 ? -dx : dx;
        b = dy < 0 ? -dy : dy;
        if (a >= 64'h80000000 || b >= 64'h80000000)
            len = 2 * root_floor((a >> 1) * (a >> 1) + (b >> 1) * (b >> 1));
        else
            len = root_floor(a * a + b * b);
        rest = longint'(cur_rest);
        if (len > EPS_RAW && !(cur_mode == MODE_BUNGEE && len <= rest))
        begin
            disp = len - rest;
            k = $signed(cur_k);
            ux = (dx * (64'sd1 <<< FRAC)) / len;
            uy = (dy * (64'sd1 <<< FRAC)) / len;
            r.fx = 32'(clip32(-mul_q(mul_q(k, ux), disp)));
            r.fy = 32'(clip32(-mul_q(mul_q(k, uy), disp)));
            r.applied = 1'b1;
        end
        return r;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_MODE:      cur_mode = val[1:0];
            REG_SPRING_K:  cur_k = val;
            REG_REST_LEN:  cur_rest = val[30:0];
            REG_ANCHOR_X:  cur_ax = val;
            REG_ANCHOR_Y:  cur_ay = val;
            REG_GRAVITY_X: cur_gx = val;
            REG_GRAVITY_Y: cur_gy = val;
            default: ;
        endcase
    endtask

    task automatic drain;
        while (pending_forces.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Sends one beat; the predictor sees the configuration in force at acceptance.
    task automatic send_particle(particle_t p, bit known, force_t f);
        int gap;
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        {pos_x, pos_y, other_x, other_y, mass, finite_mass} <= p;
        do @(posedge clk); while (in_stall);
        pending_forces.insert(pending_forces.size(), known ? f : spring_force(p));
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'h7fffffff ^ ($urandom_range(0, 1) << 31);
            2: return 32'($signed($urandom_range(0, 2000)) - 1000);
            default: return 32'($signed($urandom_range(0, 32'h00200000)) - 32'sh00100000);
        endcase
    endfunction

    function automatic particle_t rand_particle();
        particle_t p;
        p.px = rand_coord();
        p.py = rand_coord();
        if ($urandom_range(0, 3) == 0)
        begin
            p.ox = p.px + $urandom_range(0, 16) - 8;
            p.oy = p.py + $urandom_range(0, 16) - 8;
        end
        else
        begin
            p.ox = rand_coord();
            p.oy = rand_coord();
        end
        p.m = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h00080000);
        p.fin = $urandom_range(0, 3) != 0;
        return p;
    endfunction

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (pending_forces.size() == 0)
            begin
                $display("%0t: unexpected beat fx=%h fy=%h applied=%b",
                         $time, force_x, force_y, force_applied);
                n_errors++;
            end
            else
            begin
                force_t e;
                e = pending_forces.pop_front();
                if (e.fx !== force_x)
                begin
                    $display("%0t: force_x expected %h actual %h", $time, e.fx, force_x);
                    n_errors++;
                end
                if (e.fy !== force_y)
                begin
                    $display("%0t: force_y expected %h actual %h", $time, e.fy, force_y);
                    n_errors++;
                end
                if (e.applied !== force_applied)
                begin
                    $display("%0t: force_applied expected %b actual %b",
                             $time, e.applied, force_applied);
                    n_errors++;
                end
            end
        end
    end

    initial
    begin
        int wait_n;
        forever
        begin
            @(posedge clk);
            if (hold_long)
            begin
                out_stall <= 1'b1;
                repeat (3 * LATENCY) @(posedge clk);
                out_stall <= 1'b0;
                hold_long = 0;
            end
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                wait_n = $urandom_range(1, 7);
                out_stall <= 1'b1;
                repeat (wait_n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        row_t rows[$];
        logic [31:0] k_set[4];
        particle_t p;
        force_t none;
        none = '0;
        k_set = '{32'h00010000, 32'h7fffffff, 32'h80000000, 32'hfffe8000};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: gravity of zero, so every finite mass gives a zero force.
        rows.insert(rows.size(),
                    '{'{32'h7fffffff, 32'h80000000, 0, 0, 32'hffffffff, 1'b1}, 1, 65'h1});
        rows.insert(rows.size(), '{'{0, 0, 0, 0, 32'h00010000, 1'b0}, 1, none});
        foreach (rows[i])
            send_particle(rows[i].p, rows[i].known, rows[i].f);
        in_valid <= 1'b0;
        drain();
        rows.delete();

        write_reg(REG_GRAVITY_X, 32'h7fffffff);
        write_reg(REG_GRAVITY_Y, 32'h80000000);
        rows.insert(rows.size(), '{'{0, 0, 0, 0, 32'hffffffff, 1'b1}, 1,
                                   '{32'h7fffffff, 32'h80000000, 1'b1}});
        rows.insert(rows.size(), '{'{0, 0, 0, 0, 32'hffffffff, 1'b0}, 1, none});
        rows.insert(rows.size(), '{'{0, 0, 0, 0, 32'h00010000, 1'b1}, 0, none});
        rows.insert(rows.size(), '{'{0, 0, 0, 0, 32'h00000001, 1'b1}, 0, none});
        foreach (rows[i])
            send_particle(rows[i].p, rows[i].known, rows[i].f);
        in_valid <= 1'b0;
        drain();
        rows.delete();

        write_reg(REG_MODE, 32'(MODE_SPRING));
        write_reg(REG_SPRING_K, 32'h00010000);
        write_reg(REG_REST_LEN, 32'h00010000);
        // Coincident particles and a tiny separation give no force; extremes saturate.
        rows.insert(rows.size(), '{'{32'h00050000, 0, 32'h00050000, 0, 0, 0}, 1, none});
        rows.insert(rows.size(), '{'{6, 0, 0, 0, 0, 0}, 1, none});
        rows.insert(rows.size(), '{'{7, 0, 0, 0, 0, 0}, 0, none});
        rows.insert(rows.size(),
                    '{'{32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 0, 0},
                      0, none});
        rows.insert(rows.size(), '{'{32'h00030000, 32'h00040000, 0, 0, 0, 1}, 0, none});
        rows.insert(rows.size(), '{'{32'h80000000, 0, 32'h7fffffff, 0, 0, 0}, 0, none});
        foreach (rows[i])
            send_particle(rows[i].p, rows[i].known, rows[i].f);
        in_valid <= 1'b0;
        drain();
        rows.delete();

        write_reg(REG_MODE, 32'(MODE_BUNGEE));
        write_reg(REG_REST_LEN, 32'h00050000);
        rows.insert(rows.size(), '{'{32'h00030000, 32'h00040000, 0, 0, 0, 0}, 1, none});
        rows.insert(rows.size(), '{'{32'h00060000, 32'h00080000, 0, 0, 0, 0}, 0, none});
        rows.insert(rows.size(), '{'{32'h00010000, 0, 0, 0, 0, 0}, 1, none});
        foreach (rows[i])
            send_particle(rows[i].p, rows[i].known, rows[i].f);
        in_valid <= 1'b0;
        drain();
        rows.delete();

        write_reg(REG_MODE, 32'(MODE_ANCHORED));
        write_reg(REG_ANCHOR_X, 32'h80000000);
        write_reg(REG_ANCHOR_Y, 32'h7fffffff);
        write_reg(REG_REST_LEN, 32'h7fffffff);
        send_particle('{32'h7fffffff, 32'h80000000, 0, 0, 0, 0}, 0, none);
        send_particle('{32'h80000000, 32'h7fffffff, 0, 0, 0, 0}, 1, none);
        in_valid <= 1'b0;
        drain();

        // Random phases, each under a fresh configuration.
        for (int ph = 0; ph < 12; ph++)
        begin
            write_reg(REG_MODE, 32'(ph % 4));
            write_reg(REG_SPRING_K, ph < 4 ? k_set[ph] : $urandom);
            write_reg(REG_REST_LEN, ph == 5 ? 32'h0 :
                      $urandom_range(0, 1) ? $urandom_range(0, 32'h00100000) : $urandom);
            write_reg(REG_ANCHOR_X, rand_coord());
            write_reg(REG_ANCHOR_Y, rand_coord());
            write_reg(REG_GRAVITY_X, rand_coord());
            write_reg(REG_GRAVITY_Y, rand_coord());
            if (ph == 11)
                quiet_tail = 1;
            for (int n = 0; n < 125; n++)
            begin
                if (ph == 2 && n == 10)
                    hold_long = 1;
                p = rand_particle();
                send_particle(p, 0, none);
            end
            in_valid <= 1'b0;
            drain();
        end

        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
